// ===== hdl/i2t_pkg.sv =====
// shared types, constants and helper functions for the power-of-two radix
// integer to text block; no dependencies
package i2t_pkg;

	// word and datapath sizes
	localparam int WORD_BITS = 32;
	localparam int PAD_W     = WORD_BITS + 4;
	localparam int CNT_W     = $clog2(WORD_BITS + 1);
	localparam int SH_W      = $clog2(PAD_W);
	localparam int Q_DEPTH   = 2;
	localparam int QP_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W      = $clog2(Q_DEPTH + 1);

	// radix register limits and reset value
	localparam logic [2:0] RADIX_MIN   = 3'd1;
	localparam logic [2:0] RADIX_MAX   = 3'd5;
	localparam logic [2:0] RADIX_RESET = 3'd4;

	// character codes
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [4:0] DEC_DIGITS  = 5'd10;

	// one classified value waiting for the back end
	typedef struct packed {
		logic             neg;
		logic [PAD_W-1:0] word;
		logic [2:0]       rbits;
		logic [CNT_W-1:0] ndig;
	} i2t_item_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic empty;
	} i2t_qstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SIGN,
		BK_DIGITS
	} i2t_bk_state_t;

	// clamp the raw register to the supported digit widths
	function automatic logic [2:0] eff_radix(input logic [2:0] raw);
		logic [2:0] r;
		r = raw;
		if (raw < RADIX_MIN) begin
			r = RADIX_MIN;
		end else if (raw > RADIX_MAX) begin
			r = RADIX_MAX;
		end
		return r;
	endfunction

	// digit positions of a full word at a given digit width
	function automatic logic [CNT_W-1:0] ndig_of(input logic [2:0] r);
		logic [CNT_W-1:0] n;
		unique case (r)
			3'd1: n = CNT_W'(WORD_BITS);
			3'd2: n = CNT_W'((WORD_BITS + 1) / 2);
			3'd3: n = CNT_W'((WORD_BITS + 2) / 3);
			3'd4: n = CNT_W'((WORD_BITS + 3) / 4);
			default: n = CNT_W'((WORD_BITS + 4) / 5);
		endcase
		return n;
	endfunction

	// left shift that puts the top digit at the top of the padded word
	function automatic logic [SH_W-1:0] pad_of(input logic [2:0] r);
		logic [SH_W-1:0] s;
		unique case (r)
			3'd1: s = SH_W'(PAD_W - WORD_BITS);
			3'd2: s = SH_W'(PAD_W - ((WORD_BITS + 1) / 2) * 2);
			3'd3: s = SH_W'(PAD_W - ((WORD_BITS + 2) / 3) * 3);
			3'd4: s = SH_W'(PAD_W - ((WORD_BITS + 3) / 4) * 4);
			default: s = SH_W'(PAD_W - ((WORD_BITS + 4) / 5) * 5);
		endcase
		return s;
	endfunction

	// digit alphabet 0-9 then A-V
	function automatic logic [7:0] digit_char(input logic [4:0] d);
		logic [7:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + 8'(d);
		end else begin
			c = CHAR_A + 8'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

// ===== hdl/i2t_front.sv =====
// front end: radix register, input accept and classification of each value
// depends on i2t_pkg
module i2t_front import i2t_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] value,
	input  logic                 cfg_valid,
	input  logic [2:0]           radix_bits,
	input  i2t_qstat_t           qstat,
	output logic                 busy,
	output logic                 cfg_ready,
	output logic                 push,
	output i2t_item_t            item
);

	logic [2:0]           radix_q;
	logic [2:0]           r_eff;
	logic                 neg;
	logic [WORD_BITS-1:0] mag;

	// radix register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= radix_bits;
		end
	end

	// accept while the queue has room
	assign busy = qstat.full;
	assign push = start && !busy;

	// sign, magnitude and top-digit alignment
	always_comb begin
		r_eff      = eff_radix(radix_q);
		neg        = value[WORD_BITS-1];
		mag        = neg ? (~value + WORD_BITS'(1)) : value;
		item.neg   = neg;
		item.word  = PAD_W'(mag) << pad_of(r_eff);
		item.rbits = r_eff;
		item.ndig  = ndig_of(r_eff);
	end

endmodule

// ===== hdl/i2t_queue.sv =====
// short register queue between the front and back ends
// depends on i2t_pkg
module i2t_queue import i2t_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  i2t_item_t  push_item,
	input  logic       pop,
	output i2t_item_t  head,
	output i2t_qstat_t qstat
);

	i2t_item_t         entry_q [Q_DEPTH];
	logic [QP_W-1:0]   wr_ptr_q;
	logic [QP_W-1:0]   rd_ptr_q;
	logic [QC_W-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign qstat.full  = (count_q == QC_W'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + QP_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + QP_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QC_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QC_W'(1);
			end
		end
	end

endmodule

// ===== hdl/i2t_back.sv =====
// back end: digit shifter, leading zero suppression and character output
// depends on i2t_pkg
module i2t_back import i2t_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  i2t_item_t  head,
	input  logic       q_empty,
	output logic       pop,
	output logic       idle,
	output logic       char_valid,
	output logic [7:0] char_code,
	output logic       last
);

	i2t_bk_state_t    state_q, state_d;
	logic [PAD_W-1:0] sh_q, sh_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [2:0]       r_q, r_d;
	logic             started_q, started_d;
	logic             valid_q, valid_d;
	logic [7:0]       code_q, code_d;
	logic             last_q, last_d;
	logic [4:0]       top5;
	logic [4:0]       digit;
	logic             final_digit;
	logic             show;

	// top digit of the aligned word
	assign top5        = sh_q[PAD_W-1 -: 5];
	assign digit       = top5 >> (RADIX_MAX - r_q);
	assign final_digit = (left_q == CNT_W'(1));
	assign show        = (digit != '0) || started_q || final_digit;
	assign idle        = (state_q == BK_IDLE);

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			valid_q   <= 1'b0;
			started_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			valid_q   <= valid_d;
			started_q <= started_d;
		end
	end

	always_ff @(posedge clk) begin
		sh_q   <= sh_d;
		left_q <= left_d;
		r_q    <= r_d;
		code_q <= code_d;
		last_q <= last_d;
	end

	// next state, load from queue and character selection
	always_comb begin
		state_d   = state_q;
		sh_d      = sh_q;
		left_d    = left_q;
		r_d       = r_q;
		started_d = started_q;
		valid_d   = 1'b0;
		code_d    = code_q;
		last_d    = 1'b0;
		pop       = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = !q_empty;
			end
			BK_SIGN: begin
				valid_d = 1'b1;
				code_d  = CHAR_MINUS;
				state_d = BK_DIGITS;
			end
			BK_DIGITS: begin
				valid_d   = show;
				code_d    = digit_char(digit);
				last_d    = final_digit;
				started_d = started_q || show;
				sh_d      = sh_q << r_q;
				left_d    = left_q - CNT_W'(1);
				if (final_digit) begin
					state_d = BK_IDLE;
					pop     = !q_empty;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
		// start the next value right behind this one
		if (pop) begin
			sh_d      = head.word;
			left_d    = head.ndig;
			r_d       = head.rbits;
			started_d = 1'b0;
			state_d   = head.neg ? BK_SIGN : BK_DIGITS;
		end
	end

	assign char_valid = valid_q;
	assign char_code  = code_q;
	assign last       = last_q;

endmodule

// ===== hdl/pow2_radix_int_to_text_top.sv =====
// top level of the power-of-two radix integer to text block
// depends on i2t_pkg, i2t_front, i2t_queue and i2t_back
//
// Prints a signed 32-bit value in base 2, 4, 8, 16 or 32 (radix_bits 1..5,
// 0 reads as 1, 6 and 7 as 5), one ASCII character per char_valid beat,
// most significant digit first, with a leading '-' for negative values and
// last on the final character. The receiver cannot stall: each character is
// shown for exactly one cycle. A value is taken when start is high and busy
// is low; a two-entry queue lets up to two values wait while one prints.
// The digit shifter takes one digit position per cycle, leading zeros
// included (32, 16, 11, 8 or 7 positions), after a sign step for a negative
// value; values back to back follow each other with no gap, and from an
// empty block a value passes the queue entry, the back end state register
// and the output register before its first character appears.
module pow2_radix_int_to_text_top import i2t_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] value,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           radix_bits,
	output logic                 char_valid,
	output logic [7:0]           char_code,
	output logic                 last
);

	i2t_item_t  push_item;
	i2t_item_t  head;
	i2t_qstat_t qstat;
	logic       push;
	logic       pop;
	logic       bk_idle;

	i2t_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.radix_bits (radix_bits),
		.qstat      (qstat),
		.busy       (busy),
		.cfg_ready  (cfg_ready),
		.push       (push),
		.item       (push_item)
	);

	i2t_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	i2t_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (qstat.empty),
		.pop        (pop),
		.idle       (bk_idle),
		.char_valid (char_valid),
		.char_code  (char_code),
		.last       (last)
	);

`ifndef SYNTHESIS
	// the sign never ends a value's text
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_code == CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as last character");

	// an idle back end takes a waiting value at once
	a_idle_pops: assert property (@(posedge clk) disable iff (!arst_n)
		bk_idle && !qstat.empty |-> pop)
		else $error("back end idle while a value waits");

	// a non-final zero only follows another character of the same run
	a_zero_suppressed: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && (char_code == CHAR_ZERO) && !last |-> $past(char_valid))
		else $error("leading zero digit was printed");
`endif

endmodule

// ===== dv/tb_pow2_radix_int_to_text_top.sv =====
// testbench for pow2_radix_int_to_text_top: drives values and radix writes, predicts
// each character beat and compares it against char_code and last
// depends on i2t_pkg and the block's rtl
module tb_pow2_radix_int_to_text_top;
	timeunit 1ns;
	timeprecision 1ps;
	import i2t_pkg::*;

	localparam logic [7:0] ASCII_ZERO  = "0";
	localparam logic [7:0] ASCII_UPPER = "A";
	localparam logic [7:0] ASCII_DASH  = "-";
	localparam logic [31:0] MOST_NEG   = 32'h8000_0000;
	localparam logic [31:0] MOST_POS   = 32'h7FFF_FFFF;
	localparam int SETTLE_CYCLES       = 40;

	// one expected character beat
	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} text_char_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [WORD_BITS-1:0] value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [2:0]           radix_bits;
	logic                 char_valid;
	logic [7:0]           char_code;
	logic                 last;

	text_char_t pending_chars[$];
	logic [2:0] radix_reg;
	int         errors;

	pow2_radix_int_to_text_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.radix_bits(radix_bits),
		.char_valid(char_valid),
		.char_code (char_code),
		.last      (last)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop if the run hangs
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// one line per mismatch, counted
	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	// expected text of one value at the current radix register
	function automatic void predict_text(input logic [31:0] v, input logic [2:0] raw);
		logic [2:0]  r;
		logic [31:0] mag;
		logic [4:0]  digs[32];
		logic [4:0]  d;
		int          nd;
		text_char_t  c;
		r = raw;
		if (r == 3'd0) begin
			r = 3'd1;
		end else if (r > 3'd5) begin
			r = 3'd5;
		end
		mag = v[31] ? (~v + 32'd1) : v;
		nd = 0;
		if (mag == 32'd0) begin
			digs[0] = 5'd0;
			nd = 1;
		end
		while (mag != 32'd0) begin
			digs[nd] = 5'(mag & ((32'd1 << r) - 32'd1));
			mag = mag >> r;
			nd++;
		end
		// sign first, then digits most significant first
		if (v[31]) begin
			c.code = ASCII_DASH;
			c.fin = 1'b0;
			pending_chars.push_back(c);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			d = digs[i];
			c.code = (d < 5'd10) ? ASCII_ZERO + 8'(d) : ASCII_UPPER + 8'(d - 5'd10);
			c.fin = (i == 0);
			pending_chars.push_back(c);
		end
	endfunction

	// watch accepted beats on all three channels
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				radix_reg = radix_bits;
			end
			if (start && !busy) begin
				predict_text(value, radix_reg);
			end
			if (char_valid) begin
				if (pending_chars.size() == 0) begin
					report($sformatf("unexpected char 0x%02h", char_code));
				end else begin
					want = pending_chars.pop_front();
					if (char_code !== want.code) begin
						report($sformatf("char_code 0x%02h, want 0x%02h", char_code, want.code));
					end
					if (last !== want.fin) begin
						report($sformatf("last %b, want %b on 0x%02h", last, want.fin, want.code));
					end
				end
			end
		end
	end

	// drop start and hold for some cycles
	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// present one value and wait until it is taken
	task automatic send_value(input logic [31:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// let every expected character come out, then a little margin
	task automatic drain();
		pause(1);
		while (pending_chars.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write the radix register while the block is idle
	task automatic write_radix(input logic [2:0] r);
		drain();
		cfg_valid <= 1'b1;
		radix_bits <= r;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random value, biased toward short texts and corners
	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			5: v = $urandom_range(0, 40);
			6: v = -$urandom_range(1, 40);
			7: v = ($urandom_range(0, 1) != 0) ? MOST_NEG : MOST_POS;
			8: v = 32'd1 << $urandom_range(0, 31);
			9: v = $urandom >> $urandom_range(0, 31);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// corners at every register setting, reset value first
	task automatic test_directed();
		logic [2:0] order[7] = '{3'd1, 3'd5, 3'd0, 3'd6, 3'd7, 3'd2, 3'd3};
		send_value(32'd0);
		send_value(MOST_POS);
		send_value(MOST_NEG);
		send_value(32'hFFFF_FFFF);
		foreach (order[i]) begin
			write_radix(order[i]);
			send_value(MOST_NEG);
			send_value(MOST_POS);
		end
		// base 32: top letter and a negative with a letter digit
		write_radix(3'd5);
		send_value(32'd31);
		send_value(-32'sd10);
		send_value(32'h0123_4567);
	endtask

	// random values across register settings, random gaps on the start side
	task automatic test_random_radix();
		logic [2:0] order[6] = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd5};
		foreach (order[i]) begin
			write_radix(order[i]);
			repeat (20) begin
				if ($urandom_range(0, 2) == 0) begin
					pause($urandom_range(1, 13));
				end
				send_value(pick_value());
			end
		end
	endtask

	// values back to back with no gaps
	task automatic test_back_to_back();
		write_radix(3'($urandom_range(0, 7)));
		repeat (15) send_value(pick_value());
		write_radix(3'd2);
		repeat (15) send_value(pick_value());
	endtask

	initial begin
		errors = 0;
		radix_reg = RADIX_RESET;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		cfg_valid = 1'b0;
		radix_bits = RADIX_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_radix();
		test_back_to_back();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
